// ===== sv/s384_pkg.sv =====
// package for the sha-384 block compression core
// holds payload structs, round constants and sigma functions; no dependencies
`default_nettype none
package s384_pkg;
    localparam int unsigned NumCfg = 8;

    typedef struct packed {
        logic [63:0] message_word;
        logic        new_message;
    } t_in_word;

    typedef struct packed {
        logic [63:0] hash_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_word;

    // entry of the word queue between front and back
    typedef struct packed {
        logic [63:0] data;
        logic        load_iv;
        logic        last;
    } t_q_word;

    function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [63:0] bsig0(input logic [63:0] x);
        bsig0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
    endfunction

    function automatic logic [63:0] bsig1(input logic [63:0] x);
        bsig1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
    endfunction

    function automatic logic [63:0] ssig0(input logic [63:0] x);
        ssig0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
    endfunction

    function automatic logic [63:0] ssig1(input logic [63:0] x);
        ssig1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
    endfunction

    function automatic logic [63:0] round_k(input logic [6:0] t);
        logic [63:0] k;
        unique case (t)
            7'd0: k = 64'h428a2f98d728ae22; 7'd1: k = 64'h7137449123ef65cd;
            7'd2: k = 64'hb5c0fbcfec4d3b2f; 7'd3: k = 64'he9b5dba58189dbbc;
            7'd4: k = 64'h3956c25bf348b538; 7'd5: k = 64'h59f111f1b605d019;
            7'd6: k = 64'h923f82a4af194f9b; 7'd7: k = 64'hab1c5ed5da6d8118;
            7'd8: k = 64'hd807aa98a3030242; 7'd9: k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
            default: k = 64'h0;
        endcase
        round_k = k;
    endfunction
endpackage
`default_nettype wire

// ===== sv/s384_front.sv =====
// front end: takes message words, tracks position in the block, feeds a two-entry queue
// depends on s384_pkg
`default_nettype none
module s384_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  s384_pkg::t_in_word  i_word,
    output logic                o_busy,
    output logic                o_q_valid,
    output s384_pkg::t_q_word   o_q_word,
    input  wire                 i_q_pop
);
    import s384_pkg::*;

    logic [3:0] r_cnt, n_cnt;
    t_q_word    r_q [2];
    logic [1:0] r_fill;
    logic       r_rd, r_wr;
    logic       w_push;
    t_q_word    w_new;

    assign o_busy    = (r_fill == 2'd2);
    assign w_push    = i_start && !o_busy;
    assign o_q_valid = (r_fill != 2'd0);
    assign o_q_word  = r_q[r_rd];

    // classify the word: first of block may load iv, sixteenth closes block
    always_comb begin
        w_new.data    = i_word.message_word;
        w_new.load_iv = (r_cnt == 4'd0) && i_word.new_message;
        w_new.last    = (r_cnt == 4'd15);
        n_cnt         = r_cnt + 4'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 4'd0;
            r_fill <= 2'd0;
            r_rd   <= 1'b0;
            r_wr   <= 1'b0;
        end else begin
            if (w_push) begin
                r_cnt <= n_cnt;
                r_wr  <= !r_wr;
            end
            if (i_q_pop) r_rd <= !r_rd;
            r_fill <= r_fill + {1'b0, w_push} - {1'b0, i_q_pop};
        end
    end

    // queue payload
    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wr] <= w_new;
    end
endmodule
`default_nettype wire

// ===== sv/s384_back.sv =====
// back end: schedule shift line, one round per cycle, chaining add and word output
// depends on s384_pkg
`default_nettype none
module s384_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_q_valid,
    input  s384_pkg::t_q_word   i_q_word,
    output logic                o_q_pop,
    input  wire [63:0]          i_iv [8],
    output logic                o_strobe,
    output s384_pkg::t_out_word o_result
);
    import s384_pkg::*;

    localparam logic [1:0] StLoad = 2'd0;
    localparam logic [1:0] StRound = 2'd1;
    localparam logic [1:0] StAdd = 2'd2;
    localparam logic [1:0] StOut = 2'd3;

    logic [1:0]  r_st;
    logic [6:0]  r_rnd;
    logic [2:0]  r_oidx;
    logic [63:0] r_h [8];
    logic [63:0] r_v [8];
    logic [63:0] r_w [16];
    logic [63:0] w_w, w_t1, w_t2, w_sched;

    assign o_q_pop = (r_st == StLoad) && i_q_valid;

    // schedule: r_w is a shift line, oldest at 0
    assign w_sched = ssig1(r_w[14]) + r_w[9] + ssig0(r_w[1]) + r_w[0];
    assign w_w     = (r_rnd < 7'd16) ? r_w[r_rnd[3:0]] : w_sched;
    assign w_t1 = r_v[7] + bsig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
                + round_k(r_rnd) + w_w;
    assign w_t2 = bsig0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= StLoad;
            r_rnd    <= 7'd0;
            r_oidx   <= 3'd0;
            o_strobe <= 1'b0;
            for (int i = 0; i < 8; i++) r_h[i] <= 64'h0;
        end else begin
            o_strobe <= 1'b0;
            unique case (r_st)
                StLoad: begin
                    if (i_q_valid) begin
                        if (i_q_word.load_iv) begin
                            for (int i = 0; i < 8; i++) begin
                                r_h[i] <= i_iv[i];
                                r_v[i] <= i_iv[i];
                            end
                        end else begin
                            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                        end
                        for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                        r_w[15] <= i_q_word.data;
                        if (i_q_word.last) begin
                            r_st  <= StRound;
                            r_rnd <= 7'd0;
                        end
                    end
                end
                StRound: begin
                    r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + w_t1;
                    r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                    r_v[0] <= w_t1 + w_t2;
                    if (r_rnd >= 7'd16) begin
                        for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                        r_w[15] <= w_sched;
                    end
                    r_rnd <= r_rnd + 7'd1;
                    if (r_rnd == 7'd79) r_st <= StAdd;
                end
                StAdd: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    r_oidx <= 3'd0;
                    r_st   <= StOut;
                end
                StOut: begin
                    o_strobe            <= 1'b1;
                    o_result.hash_word  <= r_h[r_oidx];
                    o_result.word_index <= r_oidx;
                    o_result.last_word  <= (r_oidx == 3'd7);
                    r_oidx              <= r_oidx + 3'd1;
                    if (r_oidx == 3'd7) r_st <= StLoad;
                end
                default: r_st <= StLoad;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== sv/sha384_block_compress.sv =====
// top level of the sha-384 block compression core
// depends on s384_pkg, s384_front, s384_back
//
// channel  | handshake           | payload
// input    | i_start / o_busy    | i_in   (t_in_word)
// result   | o_valid strobe      | o_out  (t_out_word)
// config   | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// a word is queued when i_start is taken; the back end pops each queued word in
// its load state. the sixteenth word of a block then starts the rounds, the
// chaining add and the output of the eight hash words, during which nothing is popped.
// reset clears counters, queue and chain. results cannot be stalled; busy rises when
// the two-entry queue is full.
`default_nettype none
module sha384_block_compress (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    output logic                o_busy,
    input  s384_pkg::t_in_word  i_in,
    output logic                o_valid,
    output s384_pkg::t_out_word o_out,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire [2:0]           i_cfg_index,
    input  wire [63:0]          i_cfg_data
);
    import s384_pkg::*;

    logic [63:0] r_iv [NumCfg];
    logic        w_q_valid, w_q_pop;
    t_q_word     w_q_word;

    assign o_cfg_ready = 1'b1;

    // init value registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NumCfg; i++) r_iv[i] <= 64'h0;
        end else if (i_cfg_valid) begin
            r_iv[i_cfg_index] <= i_cfg_data;
        end
    end

    s384_front u_front (
        .i_clk, .i_rst_n, .i_start, .i_word(i_in), .o_busy,
        .o_q_valid(w_q_valid), .o_q_word(w_q_word), .i_q_pop(w_q_pop)
    );

    s384_back u_back (
        .i_clk, .i_rst_n, .i_q_valid(w_q_valid), .i_q_word(w_q_word),
        .o_q_pop(w_q_pop), .i_iv(r_iv), .o_strobe(o_valid), .o_result(o_out)
    );
endmodule
`default_nettype wire
